// File: rtl/rmq_pkg.sv
package rmq_pkg;

   localparam int FRAC_BITS = 14;
   localparam int DATA_W    = 16;
   localparam int ELEMS     = 9;
   localparam int PAIRS     = 3;
   localparam int RAD_W     = ((DATA_W + 2) > (FRAC_BITS + 3)) ? (DATA_W + 2) : (FRAC_BITS + 3);
   localparam int MAG_W     = RAD_W - 1;
   localparam int SQ_W      = ((MAG_W + FRAC_BITS + 1) / 2) * 2;
   localparam int ROOT_W    = SQ_W / 2;
   localparam int DEN_W     = ROOT_W + 1;
   localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
   localparam int SAT_MAX   = (2 ** (DATA_W - 1)) - 1;

   typedef enum logic [1:0] {
      PIVOT_TRACE,
      PIVOT_X,
      PIVOT_Y,
      PIVOT_Z
   } pivot_type;

   typedef logic signed [RAD_W-1:0] wide_type;

   typedef struct packed {
      pivot_type             pivot;
      logic                  bad;
      wide_type [PAIRS-1:0]  pair;
   } sq_side_type;

   typedef struct packed {
      pivot_type             pivot;
      logic                  bad;
      logic [PAIRS-1:0]      neg;
      logic [ROOT_W-2:0]     half;
   } div_side_type;

endpackage

// File: rtl/rmq_sqrt.sv
module rmq_sqrt
   import rmq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [SQ_W-1:0]   in_rad,
   input  sq_side_type       in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output sq_side_type       out_side
);

   localparam int RMW = ROOT_W + 3;

   logic              valid_ff [ROOT_W];
   logic [RMW-1:0]    rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [SQ_W-1:0]   rad_ff   [ROOT_W];
   sq_side_type       side_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic              valid_prev;
      logic [RMW-1:0]    rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [SQ_W-1:0]   rad_prev;
      sq_side_type       side_prev;
      logic [RMW-1:0]    rem_shift;
      logic [RMW-1:0]    trial;
      logic              take;
      logic [RMW-1:0]    rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [SQ_W-1:0]   rad_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign rad_prev   = in_rad;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign rad_prev   = rad_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      always_comb begin
         rem_shift = {rem_prev[RMW-3:0], rad_prev[SQ_W-1 -: 2]};
         trial     = {1'b0, root_prev, 2'b01};
         take      = (rem_shift >= trial);
         rem_in    = take ? (rem_shift - trial) : rem_shift;
         root_in   = {root_prev[ROOT_W-2:0], take};
         rad_in    = {rad_prev[SQ_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// File: rtl/rmq_div.sv
module rmq_div
   import rmq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num [PAIRS],
   input  logic [DEN_W-1:0] in_den,
   input  div_side_type     in_side,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo [PAIRS],
   output div_side_type     out_side
);

   logic             valid_ff [NUM_W];
   logic [DEN_W-1:0] den_ff   [NUM_W];
   logic [NUM_W-1:0] nq_ff    [NUM_W][PAIRS];
   logic [DEN_W-1:0] rem_ff   [NUM_W][PAIRS];
   div_side_type     side_ff  [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic             valid_prev;
      logic [DEN_W-1:0] den_prev;
      div_side_type     side_prev;
      logic [NUM_W-1:0] nq_prev  [PAIRS];
      logic [DEN_W-1:0] rem_prev [PAIRS];

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign den_prev   = in_den;
         assign side_prev  = in_side;
         for (genvar l = 0; l < PAIRS; l++) begin : g_lane
            assign nq_prev[l]  = in_num[l];
            assign rem_prev[l] = '0;
         end
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign side_prev  = side_ff[k-1];
         for (genvar l = 0; l < PAIRS; l++) begin : g_lane
            assign nq_prev[l]  = nq_ff[k-1][l];
            assign rem_prev[l] = rem_ff[k-1][l];
         end
      end

      for (genvar l = 0; l < PAIRS; l++) begin : g_lane_step
         logic [DEN_W:0]   rem_shift;
         logic             take;
         logic [DEN_W-1:0] rem_in;
         logic [NUM_W-1:0] nq_in;

         always_comb begin
            rem_shift = {rem_prev[l], nq_prev[l][NUM_W-1]};
            take      = (rem_shift >= {1'b0, den_prev});
            rem_in    = take ? DEN_W'(rem_shift - {1'b0, den_prev}) : rem_shift[DEN_W-1:0];
            nq_in     = {nq_prev[l][NUM_W-2:0], take};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               nq_ff[k][l]  <= nq_in;
               rem_ff[k][l] <= rem_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];
   for (genvar l = 0; l < PAIRS; l++) begin : g_out
      assign out_quo[l] = nq_ff[NUM_W-1][l];
   end

endmodule

// File: rtl/rotation_matrix_to_quaternion.sv
// Channel   Direction  tdata                       tuser
// req       in         m00..m22, 16 bits each      none
// rsp       out        qw, qx, qy, qz, 16 each     pivot, bad_input
//
// One request enters every cycle unless rsp stalls; there are 52 register stages from
// req to rsp. The depth comes from the square root pipeline, one root bit per stage,
// and the divider pipeline, one quotient bit per stage for all three lanes in parallel.
// Reset clears only the valid bits along the pipeline.
// A stall on rsp freezes the whole pipeline, and req_tready falls with it.
module rotation_matrix_to_quaternion
   import rmq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ELEMS*DATA_W-1:0] req_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [4*DATA_W-1:0]     rsp_tdata,  // qw, qx, qy, qz
   output logic [2:0]              rsp_tuser   // pivot, bad_input
);

   localparam wide_type ONE = wide_type'(1) <<< FRAC_BITS;

   logic en;

   logic                    s0_valid_ff;
   logic [ELEMS*DATA_W-1:0] s0_mat_ff;

   wide_type    mx [ELEMS];
   wide_type    trace;
   wide_type    s1_rad_in;
   sq_side_type s1_side_in;

   logic        s1_valid_ff;
   wide_type    s1_rad_ff;
   sq_side_type s1_side_ff;

   logic [SQ_W-1:0] sq_rad;
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   sq_side_type       sq_side;

   logic [NUM_W-1:0] su_num_in [PAIRS];
   div_side_type     su_side_in;
   logic             su_valid_ff;
   logic [NUM_W-1:0] su_num_ff [PAIRS];
   logic [DEN_W-1:0] su_den_ff;
   div_side_type     su_side_ff;

   logic             dv_valid;
   logic [NUM_W-1:0] dv_quo [PAIRS];
   div_side_type     dv_side;

   logic [DATA_W-1:0] lane_q [PAIRS];
   logic [DATA_W-1:0] pv;
   logic [DATA_W-1:0] qw_in, qx_in, qy_in, qz_in;

   logic              rsp_valid_ff;
   logic [4*DATA_W-1:0] rsp_data_ff;
   logic [2:0]        rsp_user_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_mat_ff <= req_tdata;
      end
   end

   always_comb begin
      for (int i = 0; i < ELEMS; i++) begin
         mx[i] = wide_type'($signed(s0_mat_ff[i*DATA_W +: DATA_W]));
      end
      trace = mx[0] + mx[4] + mx[8];
      s1_side_in = '0;
      if (trace >= 0) begin
         s1_side_in.pivot   = PIVOT_TRACE;
         s1_rad_in          = trace + ONE;
         s1_side_in.pair[0] = mx[5] - mx[7];
         s1_side_in.pair[1] = mx[6] - mx[2];
         s1_side_in.pair[2] = mx[1] - mx[3];
      end else if (mx[0] > mx[4] && mx[0] > mx[8]) begin
         s1_side_in.pivot   = PIVOT_X;
         s1_rad_in          = ONE + mx[0] - mx[4] - mx[8];
         s1_side_in.pair[0] = mx[1] + mx[3];
         s1_side_in.pair[1] = mx[6] + mx[2];
         s1_side_in.pair[2] = mx[5] - mx[7];
      end else if (mx[4] > mx[8]) begin
         s1_side_in.pivot   = PIVOT_Y;
         s1_rad_in          = ONE + mx[4] - mx[0] - mx[8];
         s1_side_in.pair[0] = mx[1] + mx[3];
         s1_side_in.pair[1] = mx[5] + mx[7];
         s1_side_in.pair[2] = mx[6] - mx[2];
      end else begin
         s1_side_in.pivot   = PIVOT_Z;
         s1_rad_in          = ONE + mx[8] - mx[0] - mx[4];
         s1_side_in.pair[0] = mx[6] + mx[2];
         s1_side_in.pair[1] = mx[5] + mx[7];
         s1_side_in.pair[2] = mx[1] - mx[3];
      end
      s1_side_in.bad = (s1_rad_in <= 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_rad_ff  <= s1_rad_in;
         s1_side_ff <= s1_side_in;
      end
   end

   assign sq_rad = s1_side_ff.bad ? '0 :
                   SQ_W'({s1_rad_ff[MAG_W-1:0], {FRAC_BITS{1'b0}}});

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_valid_ff),
      .in_rad    (sq_rad),
      .in_side   (s1_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   always_comb begin
      su_side_in.pivot = sq_side.pivot;
      su_side_in.bad   = sq_side.bad;
      su_side_in.half  = sq_root[ROOT_W-1:1];
      for (int l = 0; l < PAIRS; l++) begin
         logic [RAD_W-1:0] mag;
         su_side_in.neg[l] = sq_side.pair[l][RAD_W-1];
         mag = su_side_in.neg[l] ? RAD_W'(-sq_side.pair[l]) : RAD_W'(sq_side.pair[l]);
         su_num_in[l] = NUM_W'({mag[MAG_W-1:0], {FRAC_BITS{1'b0}}}) + NUM_W'(sq_root);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         su_valid_ff <= 1'b0;
      end else if (en) begin
         su_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         su_num_ff  <= su_num_in;
         su_den_ff  <= {sq_root, 1'b0};
         su_side_ff <= su_side_in;
      end
   end

   rmq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (su_valid_ff),
      .in_num    (su_num_ff),
      .in_den    (su_den_ff),
      .in_side   (su_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   always_comb begin
      for (int l = 0; l < PAIRS; l++) begin
         if (dv_side.neg[l]) begin
            lane_q[l] = (dv_quo[l] > NUM_W'(SAT_MAX)) ? {1'b1, {(DATA_W-1){1'b0}}} :
                        DATA_W'(-dv_quo[l][DATA_W-1:0]);
         end else begin
            lane_q[l] = (dv_quo[l] > NUM_W'(SAT_MAX)) ? DATA_W'(SAT_MAX) :
                        dv_quo[l][DATA_W-1:0];
         end
      end
      pv = (NUM_W'(dv_side.half) > NUM_W'(SAT_MAX)) ? DATA_W'(SAT_MAX) :
           DATA_W'(NUM_W'(dv_side.half));
      unique case (dv_side.pivot)
         PIVOT_TRACE: begin
            qw_in = pv;        qx_in = lane_q[0]; qy_in = lane_q[1]; qz_in = lane_q[2];
         end
         PIVOT_X: begin
            qx_in = pv;        qy_in = lane_q[0]; qz_in = lane_q[1]; qw_in = lane_q[2];
         end
         PIVOT_Y: begin
            qy_in = pv;        qx_in = lane_q[0]; qz_in = lane_q[1]; qw_in = lane_q[2];
         end
         default: begin
            qz_in = pv;        qx_in = lane_q[0]; qy_in = lane_q[1]; qw_in = lane_q[2];
         end
      endcase
      if (dv_side.bad) begin
         qw_in = '0;
         qx_in = '0;
         qy_in = '0;
         qz_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {qz_in, qy_in, qx_in, qw_in};
         rsp_user_ff <= {dv_side.bad, dv_side.pivot};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: rtl/rmq_checker.sv
module rmq_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [143:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [63:0]  rsp_tdata,
   input logic [2:0]   rsp_tuser
);

   // A stalled result keeps its place and its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // The pipeline only stalls when a result is waiting.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with an empty output");

   // A rejected radicand zeroes every component.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tdata == 64'd0)
      else $error("nonzero quaternion with bad_input");

   // The trace branch always has a positive radicand.
   a_trace_good: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == 2'd0 |-> !rsp_tuser[2])
      else $error("bad_input in the trace branch");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_checker (.*);
